/* hw/rtl/apu_pkg.sv */
// Shared types and constants for the alpha premultiply / unpremultiply pipeline.
// Holds the port payload structs, register index codes and the divider step function.
// No dependencies.
package apu_pkg;

   localparam int unsigned LANES           = 4;
   localparam int unsigned CSR_IDX_W       = 3;
   localparam int unsigned CSR_DATA_W      = 4;
   localparam int unsigned DIV_STEPS       = 16;
   localparam int unsigned STEPS_PER_STAGE = 2;
   localparam int unsigned DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

   localparam logic [15:0] MAX8         = 16'd255;
   localparam logic [15:0] MAX16        = 16'd65535;
   localparam logic [1:0]  ONE_COMP_BIT = 2'd3;
   localparam logic [2:0]  MAX_COMP     = 3'd4;

   localparam logic MODE_PREMUL   = 1'b0;
   localparam logic MODE_UNPREMUL = 1'b1;
   localparam logic DEPTH_8       = 1'b0;
   localparam logic DEPTH_16      = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE,
      CSR_DEPTH,
      CSR_MASK,
      CSR_SKIP,
      CSR_COUNT,
      CSR_DIVCH
   } csr_index_type;

   typedef logic [15:0] sample_type;
   typedef logic [31:0] product_type;

   typedef struct packed {
      sample_type chan0;
      sample_type chan1;
      sample_type chan2;
      sample_type chan3;
      sample_type div0;
      sample_type div1;
      sample_type div2;
      sample_type div3;
      logic       divisor_present;
   } req_type;

   typedef struct packed {
      sample_type out0;
      sample_type out1;
      sample_type out2;
      sample_type out3;
   } rsp_type;

   // masked samples, alpha and per-channel enables
   typedef struct packed {
      logic                         mode;
      logic                         depth;
      sample_type                   a;
      sample_type [LANES-1:0]       v;
      logic [LANES-1:0]             proc;
   } front_type;

   typedef struct packed {
      logic                         mode;
      logic                         depth;
      sample_type                   a;
      sample_type [LANES-1:0]       v;
      logic [LANES-1:0]             proc;
      product_type [LANES-1:0]      prod;
   } prod_stage_type;

   // sh shifts dividend bits out at the top and quotient bits in at the bottom
   typedef struct packed {
      logic       run;
      logic       sat;
      sample_type rem;
      sample_type sh;
   } lane_type;

   typedef struct packed {
      logic                   depth;
      sample_type             a;
      lane_type [LANES-1:0]   lane;
   } div_type;

   function automatic lane_type div_step(input lane_type l, input sample_type a);
      logic [16:0] rem2;
      logic [16:0] diff;
      lane_type    r;
      rem2 = {l.rem, l.sh[15]};
      diff = rem2 - {1'b0, a};
      r    = l;
      if (l.run) begin
         if (rem2 >= {1'b0, a}) begin
            r.rem = diff[15:0];
            r.sh  = {l.sh[14:0], 1'b1};
         end else begin
            r.rem = rem2[15:0];
            r.sh  = {l.sh[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/alpha_premultiply_unpremultiply_top.sv */
// Alpha premultiply / unpremultiply pipeline, one pixel of four channels per cycle.
// The input stage loads at the edge that accepts start; the multiplier, eight two-bit divider
// stages and the output register follow it before the result strobe rises.
// Throughput: one item per cycle; busy is high only during reset, the receiver cannot stall.
// Reset (synchronous) empties the pipeline and restores the register defaults.
// Depends on apu_pkg.
module alpha_premultiply_unpremultiply_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  apu_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output apu_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [apu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [apu_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned LATENCY = apu_pkg::DIV_STAGES + 3;

   // configuration registers
   logic       mode_ff,  mode_in;
   logic       depth_ff, depth_in;
   logic [3:0] mask_ff,  mask_in;
   logic [2:0] skip_ff,  skip_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] divch_ff, divch_in;

   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      mask_in  = mask_ff;
      skip_in  = skip_ff;
      count_in = count_ff;
      divch_in = divch_ff;
      if (csr_we) begin
         unique case (apu_pkg::csr_index_type'(csr_index))
            apu_pkg::CSR_MODE:  mode_in  = csr_wdata[0];
            apu_pkg::CSR_DEPTH: depth_in = csr_wdata[0];
            apu_pkg::CSR_MASK:  mask_in  = csr_wdata[3:0];
            apu_pkg::CSR_SKIP:  skip_in  = csr_wdata[2:0];
            apu_pkg::CSR_COUNT: count_in = csr_wdata[2:0];
            apu_pkg::CSR_DIVCH: divch_in = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= apu_pkg::MODE_PREMUL;
         depth_ff <= apu_pkg::DEPTH_8;
         mask_ff  <= 4'd15;
         skip_ff  <= 3'd4;
         count_ff <= 3'd4;
         divch_ff <= 2'd3;
      end else begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
         mask_ff  <= mask_in;
         skip_ff  <= skip_in;
         count_ff <= count_in;
         divch_ff <= divch_in;
      end
   end

   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // input stage: mask samples, pick alpha, decide which channels get processed
   apu_pkg::sample_type                       maxv;
   apu_pkg::sample_type [apu_pkg::LANES-1:0]  div_v;
   logic [2:0]                                ncomp;
   logic                                      active;
   logic [1:0]                                mbit;
   apu_pkg::front_type                        s1_ff, s1_in;
   logic                                      s1_valid_ff;

   always_comb begin
      maxv     = (depth_ff == apu_pkg::DEPTH_16) ? apu_pkg::MAX16 : apu_pkg::MAX8;
      div_v[0] = req_data.div0 & maxv;
      div_v[1] = req_data.div1 & maxv;
      div_v[2] = req_data.div2 & maxv;
      div_v[3] = req_data.div3 & maxv;
      s1_in.mode  = mode_ff;
      s1_in.depth = depth_ff;
      s1_in.a     = div_v[divch_ff];
      s1_in.v[0]  = req_data.chan0 & maxv;
      s1_in.v[1]  = req_data.chan1 & maxv;
      s1_in.v[2]  = req_data.chan2 & maxv;
      s1_in.v[3]  = req_data.chan3 & maxv;
      ncomp  = (count_ff > apu_pkg::MAX_COMP) ? apu_pkg::MAX_COMP : count_ff;
      active = req_data.divisor_present &&
               !(mode_ff == apu_pkg::MODE_UNPREMUL && s1_in.a == '0);
      mbit   = '0;
      for (int c = 0; c < apu_pkg::LANES; c++) begin
         mbit = (ncomp == 3'd1) ? apu_pkg::ONE_COMP_BIT : 2'(c);
         s1_in.proc[c] = active && (3'(c) < ncomp) && mask_ff[mbit] && (3'(c) != skip_ff);
      end
   end

   // multiplier stage: v*a to premultiply, v*max to feed the divider
   apu_pkg::prod_stage_type s2_ff, s2_in;
   logic                    s2_valid_ff;
   apu_pkg::sample_type     mult;

   always_comb begin
      if (s1_ff.mode == apu_pkg::MODE_UNPREMUL) begin
         mult = (s1_ff.depth == apu_pkg::DEPTH_16) ? apu_pkg::MAX16 : apu_pkg::MAX8;
      end else begin
         mult = s1_ff.a;
      end
      s2_in.mode  = s1_ff.mode;
      s2_in.depth = s1_ff.depth;
      s2_in.a     = s1_ff.a;
      s2_in.v     = s1_ff.v;
      s2_in.proc  = s1_ff.proc;
      for (int c = 0; c < apu_pkg::LANES; c++) begin
         s2_in.prod[c] = {16'd0, s1_ff.v[c]} * {16'd0, mult};
      end
   end

   // divider entry: pass-through, premultiply product divided by max, load dividend, or flag saturation
   apu_pkg::div_type entry;
   logic [32:0]      sum16;
   logic [16:0]      sum8;

   always_comb begin
      entry.depth = s2_ff.depth;
      entry.a     = s2_ff.a;
      sum16       = '0;
      sum8        = '0;
      for (int c = 0; c < apu_pkg::LANES; c++) begin
         // floor(p / (2^n - 1)) = (p + (p >> n) + 1) >> n for p up to (2^n - 1)^2
         sum16 = {1'b0, s2_ff.prod[c]} + {17'd0, s2_ff.prod[c][31:16]} + 33'd1;
         sum8  = {1'b0, s2_ff.prod[c][15:0]} + {9'd0, s2_ff.prod[c][15:8]} + 17'd1;
         entry.lane[c].run = 1'b0;
         entry.lane[c].sat = 1'b0;
         entry.lane[c].rem = '0;
         entry.lane[c].sh  = s2_ff.v[c];
         if (s2_ff.proc[c]) begin
            if (s2_ff.mode == apu_pkg::MODE_PREMUL) begin
               entry.lane[c].sh = (s2_ff.depth == apu_pkg::DEPTH_16) ?
                                  sum16[31:16] : {8'd0, sum8[15:8]};
            end else begin
               // quotient exceeds max exactly when v > a
               entry.lane[c].sat = s2_ff.v[c] > s2_ff.a;
               entry.lane[c].run = !(s2_ff.v[c] > s2_ff.a);
               entry.lane[c].rem = s2_ff.prod[c][31:16];
               entry.lane[c].sh  = (s2_ff.v[c] > s2_ff.a) ? s2_ff.v[c] : s2_ff.prod[c][15:0];
            end
         end
      end
   end

   // divider stages, two restoring steps each
   apu_pkg::div_type d_src [apu_pkg::DIV_STAGES];
   apu_pkg::div_type d_in  [apu_pkg::DIV_STAGES];
   apu_pkg::div_type d_ff  [apu_pkg::DIV_STAGES];
   logic [apu_pkg::DIV_STAGES-1:0] d_valid_ff;

   always_comb begin
      d_src[0] = entry;
      for (int k = 1; k < apu_pkg::DIV_STAGES; k++) begin
         d_src[k] = d_ff[k-1];
      end
      for (int k = 0; k < apu_pkg::DIV_STAGES; k++) begin
         d_in[k] = d_src[k];
         for (int c = 0; c < apu_pkg::LANES; c++) begin
            for (int s = 0; s < apu_pkg::STEPS_PER_STAGE; s++) begin
               d_in[k].lane[c] = apu_pkg::div_step(d_in[k].lane[c], d_src[k].a);
            end
         end
      end
   end

   // output stage
   apu_pkg::div_type    last;
   apu_pkg::sample_type out_max;
   apu_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   always_comb begin
      last    = d_ff[apu_pkg::DIV_STAGES-1];
      out_max = (last.depth == apu_pkg::DEPTH_16) ? apu_pkg::MAX16 : apu_pkg::MAX8;
      rsp_in.out0 = last.lane[0].sat ? out_max : last.lane[0].sh;
      rsp_in.out1 = last.lane[1].sat ? out_max : last.lane[1].sh;
      rsp_in.out2 = last.lane[2].sat ? out_max : last.lane[2].sh;
      rsp_in.out3 = last.lane[3].sat ? out_max : last.lane[3].sh;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         d_valid_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         d_valid_ff   <= {d_valid_ff[apu_pkg::DIV_STAGES-2:0], s2_valid_ff};
         rsp_valid_ff <= d_valid_ff[apu_pkg::DIV_STAGES-1];
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      d_ff   <= d_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without an accepted item");

   for (genvar c = 0; c < apu_pkg::LANES; c++) begin : g_chk
      a_rem_below_alpha: assert property (@(posedge clock) disable iff (reset)
         d_valid_ff[apu_pkg::DIV_STAGES-1] && d_ff[apu_pkg::DIV_STAGES-1].lane[c].run
         |-> d_ff[apu_pkg::DIV_STAGES-1].lane[c].rem < d_ff[apu_pkg::DIV_STAGES-1].a)
         else $error("divider remainder not below alpha");

      a_eight_bit_range: assert property (@(posedge clock) disable iff (reset)
         d_valid_ff[apu_pkg::DIV_STAGES-1] &&
         d_ff[apu_pkg::DIV_STAGES-1].depth == apu_pkg::DEPTH_8
         |-> d_ff[apu_pkg::DIV_STAGES-1].lane[c].sh[15:8] == 8'd0)
         else $error("eight-bit item carries high bits");
   end

endmodule
